[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define LBR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define LBR_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[sv/lbr_pkg.sv]
// ----------------------------------------------------------------------------
// lbr_pkg
// Types and constants shared by the bounded random generator modules.
// ----------------------------------------------------------------------------
package lbr_pkg;

   localparam int unsigned DATA_W = 16;
   localparam int unsigned LIM_W  = 15;

   localparam logic [DATA_W-1:0] SEED_RESET = 16'd1;
   localparam logic [DATA_W-1:0] SCALE_NUM  = 16'd32767;
   localparam logic [LIM_W-1:0]  LIMIT_MAX  = 15'd32766;

   localparam logic CMD_RAW     = 1'b0;
   localparam logic CMD_BOUNDED = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [DATA_W-1:0] limit;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              limit_clamped;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic raw_step;
      logic scale_start;
      logic take_divisor;
      logic draw_start;
      logic take_quotient;
      logic take_limit;
      logic out_load;
   } lbr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_busy;
      logic fits;
      logic tries_done;
   } lbr_stat_type;

endpackage

[sv/lbr_datapath.sv]
// ----------------------------------------------------------------------------
// lbr_datapath
// LFSR, request registers, shared bit-serial divider and output register.
// ----------------------------------------------------------------------------
module lbr_datapath
   import lbr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  req_type           req,
   input  logic              csr_we,
   input  logic [DATA_W-1:0] csr_wdata,
   input  lbr_cmd_type       ctl,
   output lbr_stat_type      stat,
   output rsp_type           rsp
);

   logic [DATA_W-1:0] lfsr_ff, lfsr_in, lfsr_next;
   logic [LIM_W-1:0]  lim_ff, lim_in;
   logic              clamp_ff, clamp_in;
   logic [DATA_W-1:0] divisor_ff, divisor_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic [DATA_W:0]   tries_ff, tries_in;
   rsp_type           rsp_ff, rsp_in;

   logic              div_busy_ff, div_busy_in;
   logic [3:0]        div_cnt_ff, div_cnt_in;
   logic [DATA_W-1:0] div_rem_ff, div_rem_in;
   logic [DATA_W-1:0] div_quo_ff, div_quo_in;
   logic [DATA_W-1:0] div_dsr_ff, div_dsr_in;
   logic [DATA_W:0]   div_shift, div_diff;
   logic              div_ge;
   logic              over;

   // x^16 + x^14 + x^13 + x^11 + 1, shifting right
   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5],
                       lfsr_ff[DATA_W-1:1]};

   assign over = (req.limit > {1'b0, LIMIT_MAX});

   assign div_shift = {div_rem_ff, div_quo_ff[DATA_W-1]};
   assign div_diff  = div_shift - {1'b0, div_dsr_ff};
   assign div_ge    = (div_shift >= {1'b0, div_dsr_ff});

   always_comb begin
      lfsr_in     = lfsr_ff;
      lim_in      = lim_ff;
      clamp_in    = clamp_ff;
      divisor_in  = divisor_ff;
      result_in   = result_ff;
      tries_in    = tries_ff;
      rsp_in      = rsp_ff;
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_dsr_in  = div_dsr_ff;

      if (ctl.load_req) begin
         lim_in   = over ? LIMIT_MAX : req.limit[LIM_W-1:0];
         clamp_in = (req.cmd == CMD_BOUNDED) && over;
         tries_in = '0;
      end

      if (ctl.raw_step) begin
         lfsr_in   = lfsr_next;
         result_in = lfsr_next;
      end

      // one quotient bit a cycle
      if (div_busy_ff) begin
         div_rem_in = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
         div_quo_in = {div_quo_ff[DATA_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff + 4'd1;
         if (div_cnt_ff == 4'hF) begin
            div_busy_in = 1'b0;
         end
      end

      if (ctl.scale_start) begin
         div_busy_in = 1'b1;
         div_cnt_in  = '0;
         div_rem_in  = '0;
         div_quo_in  = SCALE_NUM;
         div_dsr_in  = {1'b0, lim_ff} + 16'd1;
      end

      if (ctl.take_divisor) begin
         divisor_in = div_quo_ff;
      end

      if (ctl.draw_start) begin
         lfsr_in     = lfsr_next;
         tries_in    = tries_ff + 17'd1;
         div_busy_in = 1'b1;
         div_cnt_in  = '0;
         div_rem_in  = '0;
         div_quo_in  = lfsr_next;
         div_dsr_in  = divisor_ff;
      end

      if (ctl.take_quotient) begin
         result_in = div_quo_ff;
      end
      if (ctl.take_limit) begin
         result_in = {1'b0, lim_ff};
      end

      if (ctl.out_load) begin
         rsp_in.value         = result_ff;
         rsp_in.limit_clamped = clamp_ff;
      end

      // a seed write reloads the generator
      if (csr_we) begin
         lfsr_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff     <= SEED_RESET;
         div_busy_ff <= 1'b0;
      end else begin
         lfsr_ff     <= lfsr_in;
         div_busy_ff <= div_busy_in;
      end
      lim_ff     <= lim_in;
      clamp_ff   <= clamp_in;
      divisor_ff <= divisor_in;
      result_ff  <= result_in;
      tries_ff   <= tries_in;
      rsp_ff     <= rsp_in;
      div_cnt_ff <= div_cnt_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_dsr_ff <= div_dsr_in;
   end

   assign stat.div_busy   = div_busy_ff;
   assign stat.fits       = (div_quo_ff <= {1'b0, lim_ff});
   assign stat.tries_done = tries_ff[DATA_W];
   assign rsp             = rsp_ff;

endmodule

[sv/lbr_ctrl.sv]
// ----------------------------------------------------------------------------
// lbr_ctrl
// Sequencer for raw and bounded draws, and output handshake.
// ----------------------------------------------------------------------------
module lbr_ctrl
   import lbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_cmd,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  lbr_stat_type stat,
   output lbr_cmd_type  ctl
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_RAW        = 3'd1;
   localparam logic [2:0] S_SCALE_GO   = 3'd2;
   localparam logic [2:0] S_SCALE_WAIT = 3'd3;
   localparam logic [2:0] S_DRAW       = 3'd4;
   localparam logic [2:0] S_DRAW_WAIT  = 3'd5;
   localparam logic [2:0] S_DONE       = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = (req_cmd == CMD_BOUNDED) ? S_SCALE_GO : S_RAW;
            end
         end
         S_RAW: begin
            ctl.raw_step = 1'b1;
            state_in     = S_DONE;
         end
         S_SCALE_GO: begin
            ctl.scale_start = 1'b1;
            state_in        = S_SCALE_WAIT;
         end
         S_SCALE_WAIT: begin
            if (!stat.div_busy) begin
               ctl.take_divisor = 1'b1;
               state_in         = S_DRAW;
            end
         end
         S_DRAW: begin
            ctl.draw_start = 1'b1;
            state_in       = S_DRAW_WAIT;
         end
         S_DRAW_WAIT: begin
            if (!stat.div_busy) begin
               if (stat.fits) begin
                  ctl.take_quotient = 1'b1;
                  state_in          = S_DONE;
               end else if (stat.tries_done) begin
                  // saturate to the limit once the retry budget is spent
                  ctl.take_limit = 1'b1;
                  state_in       = S_DONE;
               end else begin
                  state_in = S_DRAW;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ctl.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/lfsr_bounded_random.sv]
// A 16-bit LFSR random source with raw and bounded draws. A raw draw steps the LFSR into
// result_ff and then loads the output register from S_DONE once it is free. A bounded
// draw repeats an LFSR step and a trial division until a quotient falls within the limit
// (about two tries on average): one restoring divider, one quotient bit a cycle, serves
// both the scale divisor and every trial quotient. One request is in flight at a time;
// the next may be accepted while the previous result waits in the output register. A
// limit above 32766 is clamped and flagged. Writing the seed over csr reloads the
// generator; a zero seed yields zero for every draw.
// ----------------------------------------------------------------------------
// lfsr_bounded_random
// Top level: request, response and seed write channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfsr_bounded_random
   import lbr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DATA_W-1:0] csr_wdata
);

   lbr_cmd_type  ctl;
   lbr_stat_type stat;
   logic         csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   lbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   lbr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .stat      (stat),
      .rsp       (rsp)
   );

   `LBR_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "request accepted while a draw is still running")
   `LBR_ASSERT_NEVER(a_div_restart, clock, reset, (ctl.scale_start || ctl.draw_start) && stat.div_busy, "divider restarted while busy")
   `LBR_ASSERT(a_clamped_range, clock, reset, (rsp_valid && rsp.limit_clamped) |-> (rsp.value <= {1'b0, LIMIT_MAX}), "clamped draw exceeds the maximum limit")

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded LFSR random generator. Raw and bounded
// draws are pushed through the request channel in random bursts, and every
// response is checked against an in-bench model of the LFSR and the
// rejection loop. Seeds are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import lbr_pkg::*;

   localparam int unsigned TRY_CAP = 65536;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req       = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [DATA_W-1:0] csr_wdata = '0;

   req_type           pending_reqs[$];
   rsp_type           expected_draws[$];
   logic [DATA_W-1:0] gen_state = SEED_RESET;
   int unsigned       mismatches = 0;
   logic              req_taken = 1'b0;
   int unsigned       burst_left = 1;
   int unsigned       gap_left = 0;
   int unsigned       stall_mode = 0;
   int unsigned       mode_left = 0;

   lfsr_bounded_random dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [DATA_W-1:0] lfsr_next(input logic [DATA_W-1:0] s);
      return {s[0] ^ s[2] ^ s[3] ^ s[5], s[DATA_W-1:1]};
   endfunction

   // Advance the generator copy exactly as the block does for one request
   function automatic rsp_type predict_draw(input req_type r);
      rsp_type     res;
      int unsigned bound;
      int unsigned divisor;
      int unsigned quotient;
      int unsigned tries;
      res.limit_clamped = 1'b0;
      if (r.cmd == CMD_RAW) begin
         gen_state = lfsr_next(gen_state);
         res.value = gen_state;
      end else begin
         bound = {16'd0, r.limit};
         if (bound > LIMIT_MAX) begin
            bound = LIMIT_MAX;
            res.limit_clamped = 1'b1;
         end
         divisor = SCALE_NUM / (bound + 1);
         tries = 0;
         do begin
            gen_state = lfsr_next(gen_state);
            quotient = gen_state / divisor;
            tries++;
         end while (quotient > bound && tries < TRY_CAP);
         if (quotient > bound)
            quotient = bound;
         res.value = quotient[DATA_W-1:0];
      end
      return res;
   endfunction

   task automatic queue_req(input logic cmd, input logic [DATA_W-1:0] limit);
      pending_reqs.push_back({cmd, limit});
   endtask

   // Block until every queued request has gone and every response has come back
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_draws.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_seed(input logic [DATA_W-1:0] seed);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= seed;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      gen_state = seed;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Request driver: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req       <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: free-flowing, light or heavy stalls
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 400);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 9) == 0);
         end
      endcase
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_draws.push_back(predict_draw(req));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_draws.size() == 0) begin
               $display("%0t: unexpected transaction value=%0d limit_clamped=%0b",
                        $time, rsp.value, rsp.limit_clamped);
               mismatches++;
            end else begin
               want = expected_draws.pop_front();
               if (rsp.value !== want.value) begin
                  $display("%0t: value expected %0d actual %0d",
                           $time, want.value, rsp.value);
                  mismatches++;
               end
               if (rsp.limit_clamped !== want.limit_clamped) begin
                  $display("%0t: limit_clamped expected %0b actual %0b",
                           $time, want.limit_clamped, rsp.limit_clamped);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [DATA_W-1:0] seeds[6];
      int unsigned       lim;
      logic              cmd;
      seeds[0] = 16'hFFFF;
      seeds[1] = 16'h8000;
      seeds[2] = 16'($urandom_range(1, 65535));
      seeds[3] = 16'h0001;
      seeds[4] = 16'($urandom_range(0, 65535));
      seeds[5] = 16'($urandom_range(0, 65535));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset seed, limit extremes and the clamp boundary
      queue_req(CMD_RAW, 16'd0);
      queue_req(CMD_RAW, 16'hFFFF);
      queue_req(CMD_BOUNDED, 16'd0);
      queue_req(CMD_BOUNDED, 16'd1);
      queue_req(CMD_BOUNDED, 16'd2);
      queue_req(CMD_BOUNDED, 16'd16383);
      queue_req(CMD_BOUNDED, 16'd16384);
      queue_req(CMD_BOUNDED, 16'd32765);
      queue_req(CMD_BOUNDED, 16'd32766);
      queue_req(CMD_BOUNDED, 16'd32767);
      queue_req(CMD_BOUNDED, 16'h8000);
      queue_req(CMD_BOUNDED, 16'hAAAA);
      queue_req(CMD_BOUNDED, 16'h5555);
      queue_req(CMD_BOUNDED, 16'hFFFF);
      queue_req(CMD_RAW, 16'h5555);
      queue_req(CMD_BOUNDED, 16'd100);
      drain();

      // Zero seed locks the generator at zero
      write_seed(16'h0000);
      queue_req(CMD_RAW, 16'd0);
      queue_req(CMD_BOUNDED, 16'd0);
      queue_req(CMD_BOUNDED, 16'd100);
      queue_req(CMD_BOUNDED, 16'd32766);
      queue_req(CMD_BOUNDED, 16'hFFFF);
      queue_req(CMD_RAW, 16'hFFFF);
      drain();

      foreach (seeds[p]) begin
         write_seed(seeds[p]);
         repeat (300) begin
            cmd = ($urandom_range(0, 9) < 7) ? CMD_BOUNDED : CMD_RAW;
            case ($urandom_range(0, 4))
               0: lim = $urandom_range(0, 15);
               1: lim = $urandom_range(0, 1023);
               2: lim = $urandom_range(0, 32766);
               3: lim = $urandom_range(32767, 65535);
               default: lim = $urandom & 32'hFFFF;
            endcase
            queue_req(cmd, lim[DATA_W-1:0]);
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
